FILE: rtl/core/circle_elastic_collision_core_defines.svh
// Assertion macros shared by the collision core RTL.
// No dependencies; included inside module bodies that carry assertions.
`ifndef CIRCLE_ELASTIC_COLLISION_CORE_DEFINES_SVH
`define CIRCLE_ELASTIC_COLLISION_CORE_DEFINES_SVH

// same-cycle implication
`define ECC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ECC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/ecc_pkg.sv
// Shared types and constants for the circle collision core.
// No dependencies.
package ecc_pkg;

   // operand slice of one multiplier stage
   localparam int MUL_CHUNK = 32;
   // front-to-back queue depth, power of two
   localparam int QDEPTH = 4;

   typedef struct packed {
      logic full;
      logic valid;
   } qstat_type;

   // stages of a sliced multiplier: one partial product per stage
   function automatic int mul_lat(input int aw, input int bw);
      return ((aw + MUL_CHUNK - 1) / MUL_CHUNK) * ((bw + MUL_CHUNK - 1) / MUL_CHUNK);
   endfunction

endpackage

FILE: rtl/core/circle_elastic_collision_core.sv
// Elastic collision of two circles: new velocities from centers, velocities, masses.
// Throughput one word per cycle while the output is not stalled; pairs overlap in the pipeline.
// Path: front register, queue, first products, sum stage, denominator and impulse
// products, numerator products (32-bit multiplier slices), divider stages, output register.
// A 4-entry queue lets the input keep taking words while the output is stalled, until it fills.
// Synchronous reset clears all valid state; no clearing pass, ready right after.
module circle_elastic_collision_core #(
   parameter int VALUE_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // first_pos_x, first_pos_y, second_pos_x, second_pos_y, first_vel_x, first_vel_y,
   // second_vel_x, second_vel_y, first_mass, second_mass, zero fill
   input  logic [((10*VALUE_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y, zero fill
   output logic [((4*VALUE_BITS+7)/8)*8-1:0]  rsp_tdata,
   // degenerate
   output logic [0:0] rsp_tuser
);
   import ecc_pkg::*;

   localparam int V      = VALUE_BITS;
   localparam int IW     = 10 * V + 5;
   localparam int OUT_TW = ((4 * V + 7) / 8) * 8;

   qstat_type      q_stat;
   logic           push, pop;
   logic [IW-1:0]  item, q_data;
   logic [4*V-1:0] out_vel;
   logic           out_dg;

   ecc_front #(.VALUE_BITS(V)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_fields(req_tdata[10*V-1:0]),
      .q_stat(q_stat), .push(push), .item(item)
   );

   ecc_queue #(.W(IW)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .din(item), .pop(pop), .dout(q_data), .stat(q_stat)
   );

   ecc_back #(.VALUE_BITS(V)) u_back (
      .clock(clock), .reset(reset),
      .q_stat(q_stat), .q_data(q_data), .pop(pop),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_vel(out_vel), .out_dg(out_dg)
   );

   assign rsp_tdata    = OUT_TW'(out_vel);
   assign rsp_tuser[0] = out_dg;
endmodule

FILE: rtl/core/ecc_delay.sv
// Resettable shift line that carries side data alongside the arithmetic.
// Depends on nothing.
module ecc_delay #(
   parameter int W = 8,
   parameter int N = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);
   logic [W-1:0] line_ff [N];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) line_ff[k] <= '0;
      end else if (en) begin
         line_ff[0] <= d;
         for (int k = 1; k < N; k++) line_ff[k] <= line_ff[k-1];
      end
   end

   assign q = line_ff[N-1];
endmodule

FILE: rtl/core/ecc_mul.sv
// Pipelined unsigned multiplier, one slice-by-slice partial product per stage.
// Depends on ecc_pkg (slice width).
module ecc_mul #(
   parameter int AW = 32,
   parameter int BW = 32
) (
   input  logic             clock,
   input  logic             en,
   input  logic [AW-1:0]    a,
   input  logic [BW-1:0]    b,
   output logic [AW+BW-1:0] p
);
   import ecc_pkg::*;

   localparam int CW  = MUL_CHUNK;
   localparam int NA  = (AW + CW - 1) / CW;
   localparam int NB  = (BW + CW - 1) / CW;
   localparam int NS  = NA * NB;
   localparam int PW  = AW + BW;
   localparam int AXW = NA * CW;
   localparam int BXW = NB * CW;
   localparam int PPW = 2 * CW;

   logic [AXW-1:0] a_ff [NS];
   logic [BXW-1:0] b_ff [NS];
   logic [PW-1:0]  acc_ff [NS];
   logic [AXW-1:0] a_in [NS];
   logic [BXW-1:0] b_in [NS];
   logic [PW-1:0]  acc_in [NS];

   for (genvar s = 0; s < NS; s++) begin : g_stage
      localparam int I  = s / NB;
      localparam int J  = s % NB;
      localparam int SH = CW * (I + J);
      logic [PW-1:0]  acc_src;
      logic [PPW-1:0] pp;
      logic [PW-1:0]  pp_sh;
      if (s == 0) begin : g_first
         assign a_in[s]  = AXW'(a);
         assign b_in[s]  = BXW'(b);
         assign acc_src  = '0;
      end else begin : g_next
         assign a_in[s]  = a_ff[s-1];
         assign b_in[s]  = b_ff[s-1];
         assign acc_src  = acc_ff[s-1];
      end
      assign pp        = PPW'(a_in[s][I*CW +: CW]) * PPW'(b_in[s][J*CW +: CW]);
      assign pp_sh     = PW'(pp) << SH;
      assign acc_in[s] = acc_src + pp_sh;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < NS; s++) begin
            a_ff[s]   <= a_in[s];
            b_ff[s]   <= b_in[s];
            acc_ff[s] <= acc_in[s];
         end
      end
   end

   assign p = acc_ff[NS-1];
endmodule

FILE: rtl/core/ecc_div.sv
// Pipelined restoring divider, several lanes sharing one divisor.
// Gives floor((4*num + den) / (2*den)), one quotient bit per stage.
module ecc_div #(
   parameter int NW    = 130,
   parameter int DW    = 98,
   parameter int QB    = 34,
   parameter int LANES = 4
) (
   input  logic                      clock,
   input  logic                      en,
   input  logic [LANES-1:0][NW-1:0]  num,
   input  logic [DW-1:0]             den,
   output logic [LANES-1:0][QB-1:0]  quo
);
   localparam int RW = NW + 3;

   logic [LANES-1:0][RW-1:0] rem_ff [QB+1];
   logic [LANES-1:0][RW-1:0] rem_in [QB+1];
   logic [DW:0]              d_ff [QB+1];
   logic [DW:0]              d_in [QB+1];
   logic [LANES-1:0][QB-1:0] q_ff [QB+1];
   logic [LANES-1:0][QB-1:0] q_in [QB+1];

   for (genvar k = 0; k <= QB; k++) begin : g_stage
      if (k == 0) begin : g_entry
         // rounding bias folded in: 4 num + den over 2 den
         assign d_in[k] = {den, 1'b0};
         assign q_in[k] = '0;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_in[k][l] = RW'({num[l], 2'b00}) + RW'(den);
         end
      end else begin : g_bit
         localparam int B = QB - k;
         logic [RW-1:0] dsh;
         assign dsh     = RW'(d_ff[k-1]) << B;
         assign d_in[k] = d_ff[k-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic ge;
            assign ge           = rem_ff[k-1][l] >= dsh;
            assign rem_in[k][l] = ge ? rem_ff[k-1][l] - dsh : rem_ff[k-1][l];
            assign q_in[k][l]   = {q_ff[k-1][l][QB-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= QB; k++) begin
            rem_ff[k] <= rem_in[k];
            d_ff[k]   <= d_in[k];
            q_ff[k]   <= q_in[k];
         end
      end
   end

   assign quo = q_ff[QB];
endmodule

FILE: rtl/core/ecc_queue.sv
// Short register queue between the front and the back of the collision core.
// Depends on ecc_pkg and the assertion macro header.
module ecc_queue #(
   parameter int W = 325
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [W-1:0]      din,
   input  logic              pop,
   output logic [W-1:0]      dout,
   output ecc_pkg::qstat_type stat
);
   import ecc_pkg::*;
   `include "circle_elastic_collision_core_defines.svh"

   localparam int PTW  = $clog2(QDEPTH);
   localparam int CNTW = $clog2(QDEPTH + 1);

   logic [W-1:0]    mem_ff [QDEPTH];
   logic [PTW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= din;
   end

   assign dout       = mem_ff[rd_ptr_ff];
   assign stat.full  = count_ff == CNTW'(QDEPTH);
   assign stat.valid = count_ff != '0;

   `ECC_ASSERT_SAME(a_no_overflow, clock, reset, push, !stat.full, "push into full queue")
   `ECC_ASSERT_SAME(a_no_underflow, clock, reset, pop, stat.valid, "pop from empty queue")
   `ECC_ASSERT_NEXT(a_pass_through, clock, reset, push && pop, $stable(count_ff), "count moved")
   `ECC_ASSERT_NEXT(a_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1, "count off")
endmodule

FILE: rtl/core/ecc_front.sv
// Input stage: takes a word, forms center and velocity differences as
// sign/magnitude, flags degenerate pairs, and pushes the item to the queue.
module ecc_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [10*VALUE_BITS-1:0]  req_fields,
   input  ecc_pkg::qstat_type        q_stat,
   output logic                      push,
   output logic [10*VALUE_BITS+4:0]  item
);
   import ecc_pkg::*;

   localparam int V  = VALUE_BITS;
   localparam int IW = 10 * V + 5;

   logic          valid_ff, valid_in;
   logic [IW-1:0] item_ff, item_in;
   logic          accept;

   logic [V-1:0] p1x, p1y, p2x, p2y, v1x, v1y, v2x, v2y, ma, mb;
   logic [V:0]   dx_f, dx_r, dy_f, dy_r, dvx_f, dvx_r, dvy_f, dvy_r;
   logic [V-1:0] dxm, dym, dvxm, dvym;
   logic         dg;

   assign {mb, ma, v2y, v2x, v1y, v1x, p2y, p2x, p1y, p1x} = req_fields;

   // both directions of each difference in parallel, pick by sign
   assign dx_f  = {p2x[V-1], p2x} - {p1x[V-1], p1x};
   assign dx_r  = {p1x[V-1], p1x} - {p2x[V-1], p2x};
   assign dy_f  = {p2y[V-1], p2y} - {p1y[V-1], p1y};
   assign dy_r  = {p1y[V-1], p1y} - {p2y[V-1], p2y};
   assign dvx_f = {v2x[V-1], v2x} - {v1x[V-1], v1x};
   assign dvx_r = {v1x[V-1], v1x} - {v2x[V-1], v2x};
   assign dvy_f = {v2y[V-1], v2y} - {v1y[V-1], v1y};
   assign dvy_r = {v1y[V-1], v1y} - {v2y[V-1], v2y};

   assign dxm  = dx_f[V]  ? dx_r[V-1:0]  : dx_f[V-1:0];
   assign dym  = dy_f[V]  ? dy_r[V-1:0]  : dy_f[V-1:0];
   assign dvxm = dvx_f[V] ? dvx_r[V-1:0] : dvx_f[V-1:0];
   assign dvym = dvy_f[V] ? dvy_r[V-1:0] : dvy_f[V-1:0];

   // coincident centers or zero mass sum
   assign dg = (dx_f == '0 && dy_f == '0) || (ma == '0 && mb == '0);

   assign req_tready = !valid_ff || !q_stat.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = valid_ff && !q_stat.full;

   always_comb begin
      valid_in = valid_ff;
      if (accept)    valid_in = 1'b1;
      else if (push) valid_in = 1'b0;
      item_in = {dg, v2y, v2x, v1y, v1x, mb, ma,
                 dvy_f[V], dvym, dvx_f[V], dvxm, dy_f[V], dym, dx_f[V], dxm};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= item_in;
   end

   assign item = item_ff;
endmodule

FILE: rtl/core/ecc_back.sv
// Execution pipeline: products, dot product and squared distance, the two
// impulse divisions per circle, rounding, saturation and the output register.
module ecc_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ecc_pkg::qstat_type        q_stat,
   input  logic [10*VALUE_BITS+4:0]  q_data,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [4*VALUE_BITS-1:0]   out_vel,
   output logic                      out_dg
);
   import ecc_pkg::*;

   localparam int V    = VALUE_BITS;
   localparam int SQW  = 2 * V + 1;
   localparam int DTW  = 2 * V + 1;
   localparam int MSW  = V + 1;
   localparam int DENW = MSW + SQW;
   localparam int KW   = MSW + DTW;
   localparam int NW   = V + KW;
   localparam int QB   = V + 2;
   localparam int SW   = V + 4;
   localparam int L1   = mul_lat(V, V);
   localparam int L2   = mul_lat(MSW, SQW);
   localparam int L3   = mul_lat(V, KW);
   localparam int LD   = QB + 1;
   localparam int S1W  = 8 * V + 6;
   localparam int S2W  = 6 * V + 5;
   localparam int S4W  = 4 * V + 6;
   localparam int S3W  = S4W + DENW;

   logic en;

   // queue item
   logic         i_dg, i_dxn, i_dyn, i_dvxn, i_dvyn;
   logic [V-1:0] i_dxm, i_dym, i_dvxm, i_dvym, i_ma, i_mb;
   logic [4*V-1:0] i_vel;

   assign {i_dg, i_vel, i_mb, i_ma, i_dvyn, i_dvym, i_dvxn, i_dvxm,
           i_dyn, i_dym, i_dxn, i_dxm} = q_data;

   assign en  = !out_valid || out_ready;
   assign pop = en && q_stat.valid;

   // first products
   logic [2*V-1:0] p_xx, p_yy, p_vx, p_vy;
   logic [S1W-1:0] d1;
   logic           d1_valid, d1_sgx, d1_sgy, d1_dg, d1_dyn, d1_dxn;
   logic [4*V-1:0] d1_vel;
   logic [V-1:0]   d1_mb, d1_ma, d1_dym, d1_dxm;

   ecc_mul #(.AW(V), .BW(V)) u_mul_xx (.clock(clock), .en(en), .a(i_dxm), .b(i_dxm), .p(p_xx));
   ecc_mul #(.AW(V), .BW(V)) u_mul_yy (.clock(clock), .en(en), .a(i_dym), .b(i_dym), .p(p_yy));
   ecc_mul #(.AW(V), .BW(V)) u_mul_vx (.clock(clock), .en(en), .a(i_dvxm), .b(i_dxm), .p(p_vx));
   ecc_mul #(.AW(V), .BW(V)) u_mul_vy (.clock(clock), .en(en), .a(i_dvym), .b(i_dym), .p(p_vy));

   ecc_delay #(.W(S1W), .N(L1)) u_side1 (
      .clock(clock), .reset(reset), .en(en),
      .d({pop, i_dvxn ^ i_dxn, i_dvyn ^ i_dyn, i_dg, i_vel, i_mb, i_ma,
          i_dyn, i_dym, i_dxn, i_dxm}),
      .q(d1)
   );
   assign {d1_valid, d1_sgx, d1_sgy, d1_dg, d1_vel, d1_mb, d1_ma,
           d1_dyn, d1_dym, d1_dxn, d1_dxm} = d1;

   // squared distance, dot product as sign/magnitude, mass sum
   logic [SQW-1:0]   sq_in, s_sq_ff;
   logic [DTW-1:0]   sum_v, dab, dba, dmag_in, s_dmag_ff;
   logic             dneg_in, s_dneg_ff, s_valid_ff;
   logic [MSW-1:0]   msum_in, s_msum_ff;
   logic [V-1:0]     s_ma_ff, s_mb_ff;
   logic [6*V+2:0]   s_rest_ff;

   assign sq_in   = {1'b0, p_xx} + {1'b0, p_yy};
   assign sum_v   = {1'b0, p_vx} + {1'b0, p_vy};
   assign dab     = {1'b0, p_vx} - {1'b0, p_vy};
   assign dba     = {1'b0, p_vy} - {1'b0, p_vx};
   assign msum_in = {1'b0, d1_ma} + {1'b0, d1_mb};

   always_comb begin
      if (d1_sgx == d1_sgy) begin
         dmag_in = sum_v;
         dneg_in = d1_sgx;
      end else if (!dab[DTW-1]) begin
         dmag_in = dab;
         dneg_in = d1_sgx;
      end else begin
         dmag_in = dba;
         dneg_in = d1_sgy;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)   s_valid_ff <= 1'b0;
      else if (en) s_valid_ff <= d1_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_sq_ff   <= sq_in;
         s_dmag_ff <= dmag_in;
         s_dneg_ff <= dneg_in;
         s_msum_ff <= msum_in;
         s_ma_ff   <= d1_ma;
         s_mb_ff   <= d1_mb;
         s_rest_ff <= {d1_dg, d1_vel, d1_dyn, d1_dym, d1_dxn, d1_dxm};
      end
   end

   // denominator and the two impulse scales
   logic [DENW-1:0] den;
   logic [KW-1:0]   ka, kb;
   logic [S2W-1:0]  d2;
   logic            d2_valid, d2_dneg, d2_dg, d2_dyn, d2_dxn;
   logic [4*V-1:0]  d2_vel;
   logic [V-1:0]    d2_dym, d2_dxm;
   logic [3:0]      d2_neg;

   ecc_mul #(.AW(MSW), .BW(SQW)) u_mul_den (
      .clock(clock), .en(en), .a(s_msum_ff), .b(s_sq_ff), .p(den));
   ecc_mul #(.AW(MSW), .BW(DTW)) u_mul_ka (
      .clock(clock), .en(en), .a({1'b0, s_mb_ff}), .b(s_dmag_ff), .p(ka));
   ecc_mul #(.AW(MSW), .BW(DTW)) u_mul_kb (
      .clock(clock), .en(en), .a({1'b0, s_ma_ff}), .b(s_dmag_ff), .p(kb));

   ecc_delay #(.W(S2W), .N(L2)) u_side2 (
      .clock(clock), .reset(reset), .en(en),
      .d({s_valid_ff, s_dneg_ff, s_rest_ff}), .q(d2)
   );
   assign {d2_valid, d2_dneg, d2_dg, d2_vel, d2_dyn, d2_dym, d2_dxn, d2_dxm} = d2;

   // second circle gets the opposite impulse
   assign d2_neg = {~(d2_dyn ^ d2_dneg), ~(d2_dxn ^ d2_dneg),
                    d2_dyn ^ d2_dneg, d2_dxn ^ d2_dneg};

   // numerators, lanes ordered first x, first y, second x, second y
   logic [3:0][NW-1:0] num;
   logic [S3W-1:0]     d3;
   logic               d3_valid, d3_dg;
   logic [4*V-1:0]     d3_vel;
   logic [3:0]         d3_neg;
   logic [DENW-1:0]    d3_den;

   ecc_mul #(.AW(V), .BW(KW)) u_mul_n1x (.clock(clock), .en(en), .a(d2_dxm), .b(ka), .p(num[0]));
   ecc_mul #(.AW(V), .BW(KW)) u_mul_n1y (.clock(clock), .en(en), .a(d2_dym), .b(ka), .p(num[1]));
   ecc_mul #(.AW(V), .BW(KW)) u_mul_n2x (.clock(clock), .en(en), .a(d2_dxm), .b(kb), .p(num[2]));
   ecc_mul #(.AW(V), .BW(KW)) u_mul_n2y (.clock(clock), .en(en), .a(d2_dym), .b(kb), .p(num[3]));

   ecc_delay #(.W(S3W), .N(L3)) u_side3 (
      .clock(clock), .reset(reset), .en(en),
      .d({d2_valid, d2_dg, d2_vel, d2_neg, den}), .q(d3)
   );
   assign {d3_valid, d3_dg, d3_vel, d3_neg, d3_den} = d3;

   // rounded quotient magnitudes; top bit set means the change saturates
   logic [3:0][QB-1:0] quo;
   logic [S4W-1:0]     d4;
   logic               d4_valid, d4_dg;
   logic [4*V-1:0]     d4_vel;
   logic [3:0]         d4_neg;

   ecc_div #(.NW(NW), .DW(DENW), .QB(QB), .LANES(4)) u_div (
      .clock(clock), .en(en), .num(num), .den(d3_den), .quo(quo)
   );

   ecc_delay #(.W(S4W), .N(LD)) u_side4 (
      .clock(clock), .reset(reset), .en(en),
      .d({d3_valid, d3_dg, d3_vel, d3_neg}), .q(d4)
   );
   assign {d4_valid, d4_dg, d4_vel, d4_neg} = d4;

   // apply change and saturate; degenerate pairs keep their velocities
   logic [4*V-1:0] vel_in;

   for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [V-1:0]  v;
      logic [SW-1:0] sv, zq, sum_add, sum_sub, sum;
      logic          ovf;
      logic [V-1:0]  res;
      assign v       = d4_vel[l*V +: V];
      assign sv      = {{(SW-V){v[V-1]}}, v};
      assign zq      = SW'(quo[l]);
      assign sum_add = sv + zq;
      assign sum_sub = sv - zq;
      assign sum     = d4_neg[l] ? sum_sub : sum_add;
      assign ovf     = |sum[SW-1:V-1] && !(&sum[SW-1:V-1]);
      assign res     = ovf ? (sum[SW-1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}})
                           : sum[V-1:0];
      assign vel_in[l*V +: V] = d4_dg ? v : res;
   end

   logic           out_valid_ff;
   logic [4*V-1:0] out_vel_ff;
   logic           out_dg_ff;

   always_ff @(posedge clock) begin
      if (reset)   out_valid_ff <= 1'b0;
      else if (en) out_valid_ff <= d4_valid;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_vel_ff <= vel_in;
         out_dg_ff  <= d4_dg;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vel   = out_vel_ff;
   assign out_dg    = out_dg_ff;
endmodule

FILE: dv/circle_elastic_collision_core_checker.sv
// Checker for the circle collision core: predicts each new-velocity word from
// the accepted request words and compares the response stream. Depends on nothing.
module circle_elastic_collision_core_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [319:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,
   input  logic [0:0]   rsp_tuser,
   output int           mismatches,
   output int           pending,
   output int           responses,
   output int           degenerate_seen
);

   typedef struct {
      logic [31:0] vel [4];
      logic        degenerate;
   } velocity_word_type;

   velocity_word_type expected_velocities[$];

   assign pending = expected_velocities.size();

   initial begin
      mismatches = 0;
      responses = 0;
      degenerate_seen = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on response %0d, %s: got %h, want %h", responses, what, got, want);
      mismatches++;
   endtask

   // exact quotient, nearest with ties away from zero, magnitude capped at 2^62
   function automatic logic signed [63:0] rounded_quotient(logic signed [255:0] num,
                                                           logic signed [255:0] den);
      logic [255:0] mag;
      logic [255:0] q;
      logic         neg;
      neg = num[255];
      mag = neg ? -num : num;
      q = (2 * mag + den) / (2 * den);
      if (q >= (256'd1 << 62)) q = 256'd1 << 62;
      return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
   endfunction

   function automatic logic [31:0] saturate(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic velocity_word_type collide(logic [319:0] d);
      velocity_word_type r;
      logic signed [255:0] f [8];
      logic signed [255:0] ma, mb, dx, dy, sq, msum, dot, den, ka, kb;
      logic signed [63:0]  v [4];
      for (int i = 0; i < 8; i++) f[i] = $signed(d[32*i +: 32]);
      ma = {224'd0, d[287:256]};
      mb = {224'd0, d[319:288]};
      for (int i = 0; i < 4; i++) v[i] = $signed(d[32*(i+4) +: 32]);
      dx = f[2] - f[0];
      dy = f[3] - f[1];
      sq = dx * dx + dy * dy;
      msum = ma + mb;
      for (int i = 0; i < 4; i++) r.vel[i] = d[32*(i+4) +: 32];
      r.degenerate = (sq == 0) || (msum == 0);
      if (!r.degenerate) begin
         dot = (f[6] - f[4]) * dx + (f[7] - f[5]) * dy;
         den = msum * sq;
         ka = 2 * mb * dot;
         kb = -(2 * ma * dot);
         r.vel[0] = saturate(v[0] + rounded_quotient(dx * ka, den));
         r.vel[1] = saturate(v[1] + rounded_quotient(dy * ka, den));
         r.vel[2] = saturate(v[2] + rounded_quotient(dx * kb, den));
         r.vel[3] = saturate(v[3] + rounded_quotient(dy * kb, den));
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_velocities.insert(expected_velocities.size(), collide(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_velocities.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata[31:0], 32'd0);
            end else begin
               velocity_word_type e;
               e = expected_velocities.pop_front();
               if (rsp_tdata[31:0] !== e.vel[0])
                  report_mismatch("new_first_vel_x", rsp_tdata[31:0], e.vel[0]);
               if (rsp_tdata[63:32] !== e.vel[1])
                  report_mismatch("new_first_vel_y", rsp_tdata[63:32], e.vel[1]);
               if (rsp_tdata[95:64] !== e.vel[2])
                  report_mismatch("new_second_vel_x", rsp_tdata[95:64], e.vel[2]);
               if (rsp_tdata[127:96] !== e.vel[3])
                  report_mismatch("new_second_vel_y", rsp_tdata[127:96], e.vel[3]);
               if (rsp_tuser[0] !== e.degenerate)
                  report_mismatch("degenerate", {31'd0, rsp_tuser[0]}, {31'd0, e.degenerate});
               if (e.degenerate) degenerate_seen++;
            end
            responses++;
         end
      end
   end

endmodule

FILE: dv/circle_elastic_collision_core_tb.sv
// Top of the collision core testbench: clock, reset, request stimulus and
// response back-pressure. Depends on the core and circle_elastic_collision_core_checker.
module circle_elastic_collision_core_tb;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [319:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;
   logic [0:0]   rsp_tuser;

   int mismatches, pending, responses, degenerate_seen;
   int sender_idle_pct, receiver_idle_pct;
   int hold_cycles;
   int sent;

   circle_elastic_collision_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   circle_elastic_collision_core_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .mismatches(mismatches), .pending(pending), .responses(responses),
      .degenerate_seen(degenerate_seen)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(20 * 300000);
      $display("timeout with %0d words outstanding", pending);
      $display("FAILED: results differ");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off whenever hold_cycles is set
   initial begin
      rsp_tready = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   task automatic send_pair(input logic [31:0] p1x, p1y, p2x, p2y,
                            input logic [31:0] v1x, v1y, v2x, v2y, m1, m2);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata <= {$urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom};
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {m2, m1, v2y, v2x, v1y, v1x, p2y, p2x, p1y, p1x};
      do @(posedge clock); while (!req_tready);
      sent++;
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // value kinds: full range, small around zero, or an extreme
   function automatic logic [31:0] pick_value(input int kind);
      case (kind)
         0: return $urandom;
         1: return $urandom_range(2 ** 21) - 2 ** 20;
         default: begin
            case ($urandom_range(3))
               0: return 32'h7fffffff;
               1: return 32'h80000000;
               2: return 32'hffffffff;
               default: return 32'h0;
            endcase
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_mass(input int kind);
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hffffffff;
         2, 3: return $urandom;
         default: return kind == 1 ? $urandom_range(1 << 20) : $urandom;
      endcase
   endfunction

   task automatic send_random_pair();
      int kind, shape;
      logic [31:0] p1x, p1y, p2x, p2y, m1, m2;
      kind = $urandom_range(9) < 5 ? 1 : ($urandom_range(9) < 8 ? 0 : 2);
      shape = $urandom_range(19);
      p1x = pick_value(kind);
      p1y = pick_value(kind);
      p2x = pick_value(kind);
      p2y = pick_value(kind);
      m1 = pick_mass(kind);
      m2 = pick_mass(kind);
      if (shape == 0) begin
         p2x = p1x;
         p2y = p1y;
      end else if (shape == 1) begin
         m1 = 0;
         m2 = 0;
      end else if (shape < 8) begin
         // touching-style pair: second center a short hop away
         p2x = p1x + $urandom_range(2 ** 18) - 2 ** 17;
         p2y = p1y + $urandom_range(2 ** 18) - 2 ** 17;
      end
      send_pair(p1x, p1y, p2x, p2y, pick_value(kind), pick_value(kind),
                pick_value(kind), pick_value(kind), m1, m2);
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      hold_cycles = 0;
      sent = 0;
      sender_idle_pct = 8;
      receiver_idle_pct = 52;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, degenerate inputs, head-on, glancing, saturation
      send_pair(0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000);
      send_pair(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'hffff0000, 32'hfffe0000, 32'h8000,
                32'h30000, 32'h10000);
      send_pair(32'h1234, 32'h5678, 32'h1234, 32'h5678, 32'h10000, 32'h20000, 3, 4,
                32'h10000, 32'h10000);
      send_pair(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 5, 6, 0, 0);
      send_pair(0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0, 0, 32'h10000);
      send_pair(0, 0, 32'h10000, 0, 32'h10000, 0, 0, 0, 32'h10000, 0);
      send_pair(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
                32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff, 32'hffffffff);
      send_pair(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'hffffffff, 1);
      send_pair(32'h80000000, 0, 32'h7fffffff, 0, 32'h7fffffff, 0, 32'h80000000, 0,
                1, 32'hffffffff);
      send_pair(0, 0, 1, 0, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                1, 32'hffffffff);
      send_pair(0, 0, 1, 1, 1, 0, 0, 0, 1, 1);
      send_pair(0, 0, 1, 1, 1, 0, 0, 0, 1, 2);
      send_pair(0, 0, 3, 0, 0, 32'hffffffff, 32'hffffffff, 0, 1, 2);
      send_pair(0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000);
      send_pair(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_pair(0, 0, 32'h10000, 0, 32'hffff0000, 0, 32'h10000, 0, 32'h10000, 32'h10000);
      send_pair(0, 0, 32'h100, 32'h200, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'hffffffff, 0);

      repeat (190) send_random_pair();
      stop_sending();
      wait_drained();

      sender_idle_pct = 52;
      receiver_idle_pct = 8;
      repeat (190) send_random_pair();
      stop_sending();
      wait_drained();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_cycles = 200;
      repeat (200) send_random_pair();
      stop_sending();
      wait_drained();
      repeat (60) @(posedge clock);

      $display("sent %0d collision pairs, %0d responses checked, %0d degenerate",
               sent, responses, degenerate_seen);
      $display("covered field extremes, coincident centers, zero mass, saturation, stalls");
      if (mismatches == 0 && pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
